// ===== rtl/grc_pkg.sv =====
package grc_pkg;

   // Map geometry
   localparam int MAP_SIDE  = 8;
   localparam int SIDE_BITS = $clog2(MAP_SIDE);
   localparam int CELLS     = MAP_SIDE * MAP_SIDE;
   localparam int CELL_BITS = $clog2(CELLS);

   // Cell index strides for the four walk directions
   localparam logic [CELL_BITS-1:0] STRIDE_X_POS = CELL_BITS'(1);
   localparam logic [CELL_BITS-1:0] STRIDE_X_NEG = CELL_BITS'(CELLS - 1);
   localparam logic [CELL_BITS-1:0] STRIDE_Y_POS = CELL_BITS'(MAP_SIDE);
   localparam logic [CELL_BITS-1:0] STRIDE_Y_NEG = CELL_BITS'(CELLS - MAP_SIDE);

   // Request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_CAST  = 1'b1;

   // Register indexes
   localparam logic REG_PLAYER_X = 1'b0;
   localparam logic REG_PLAYER_Y = 1'b1;

   localparam logic [10:0] PLAYER_X_RESET = 11'd940;
   localparam logic [10:0] PLAYER_Y_RESET = 11'd836;

   // Reciprocal constants
   localparam logic [17:0] RCP_SEED = 18'h2EA00;
   localparam logic [17:0] RCP_TWO  = 18'h20000;

   localparam logic [15:0] SMALL_MAG   = 16'd4;
   localparam logic [29:0] STEP_MAX    = 30'h3FFFFFFF;
   localparam logic [30:0] DIST_MAX    = 31'h7FFFFFFF;
   localparam logic [15:0] HIT_SAT     = 16'hFFFF;
   localparam logic [7:0]  FRAC_MIRROR = 8'hFF;

   typedef struct packed {
      logic busy;
      logic done;
   } rcp_status_type;

endpackage

// ===== rtl/grc_recip.sv =====
// Fixed-point reciprocal: normalize, seed, one Newton-Raphson refinement, denormalize.
module grc_recip (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [15:0]             operand,
   output grc_pkg::rcp_status_type status,
   output logic [32:0]             result
);

   localparam logic [2:0] P_IDLE   = 3'd0;
   localparam logic [2:0] P_NORM   = 3'd1;
   localparam logic [2:0] P_MUL    = 3'd2;
   localparam logic [2:0] P_REFINE = 3'd3;
   localparam logic [2:0] P_SHIFT  = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic        done_ff, done_in;
   logic [15:0] d_ff;
   logic [15:0] dn_ff;
   logic [3:0]  cnt_ff;
   logic [8:0]  xs_ff;
   logic [16:0] m_ff;
   logic [17:0] q_ff;
   logic [32:0] result_ff;

   logic [15:0] norm_d;
   logic [3:0]  norm_cnt;
   logic [17:0] seed;
   logic [24:0] m_prod;
   logic [17:0] y_full;
   logic [25:0] q_prod;
   logic [32:0] q_wide;

   // Log shifter: bring the leading one to bit 15
   always_comb begin
      norm_d   = d_ff;
      norm_cnt = '0;
      if (norm_d[15:8] == 8'd0) begin
         norm_d      = {norm_d[7:0], 8'd0};
         norm_cnt[3] = 1'b1;
      end
      if (norm_d[15:12] == 4'd0) begin
         norm_d      = {norm_d[11:0], 4'd0};
         norm_cnt[2] = 1'b1;
      end
      if (norm_d[15:14] == 2'd0) begin
         norm_d      = {norm_d[13:0], 2'd0};
         norm_cnt[1] = 1'b1;
      end
      if (!norm_d[15]) begin
         norm_d      = {norm_d[14:0], 1'b0};
         norm_cnt[0] = 1'b1;
      end
   end

   assign seed   = grc_pkg::RCP_SEED - {1'b0, norm_d, 1'b0};
   assign m_prod = {9'd0, dn_ff} * {16'd0, xs_ff};
   assign y_full = grc_pkg::RCP_TWO - {1'b0, m_ff};
   assign q_prod = {17'd0, xs_ff} * {9'd0, y_full[16:0]};
   assign q_wide = {15'd0, q_ff};

   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      case (phase_ff)
         P_IDLE:   if (start) phase_in = P_NORM;
         P_NORM:   phase_in = P_MUL;
         P_MUL:    phase_in = P_REFINE;
         P_REFINE: phase_in = P_SHIFT;
         P_SHIFT: begin
            phase_in = P_IDLE;
            done_in  = 1'b1;
         end
         default:  phase_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (phase_ff == P_IDLE && start) d_ff <= operand;
      if (phase_ff == P_NORM) begin
         dn_ff  <= norm_d;
         cnt_ff <= norm_cnt;
         xs_ff  <= seed[16:8];
      end
      if (phase_ff == P_MUL)    m_ff      <= m_prod[24:8];
      if (phase_ff == P_REFINE) q_ff      <= q_prod[25:8];
      if (phase_ff == P_SHIFT)  result_ff <= q_wide << cnt_ff;
   end

   assign status.busy = (phase_ff != P_IDLE);
   assign status.done = done_ff;
   assign result      = result_ff;

endmodule

// ===== rtl/grid_raycast_wall_height_top.sv =====
// Channel  Dir  Handshake          Payload
// req      in   req_tvalid/tready  tdata: cell_index, cell_value, ray_u, ray_v; tuser: req_type
// rsp      out  rsp_tvalid/tready  tdata: wall_height, wall_texture; tuser: no_hit
// csr      in   APB psel/penable   player_x at 0x0, player_y at 0x4
//
// A map write is stored as it is accepted. A cast takes the reciprocal of each ray component,
// then reads the map once per visited cell (at most MAX_STEPS), reads a neighbor cell for the
// texture when the wall was met stepping in the negative direction, and takes the reciprocal
// of the hit distance for the height. A walk that runs out of steps skips the height pass.
// Components below 4, or a zero distance, skip a reciprocal pass.
// Synchronous reset clears control and loads player position defaults; map is not cleared.
// A finished word waits in the output register; the next word is taken meanwhile.
module grid_raycast_wall_height_top #(
   parameter int MAX_STEPS   = 16,
   parameter int HALF_HEIGHT = 160
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [5:0] cell_index, [12:6] cell_value,
                                    // [28:13] ray_u, [44:29] ray_v, [47:45] zero
   input  logic [0:0]  req_tuser,   // [0] req_type

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] wall_height, [15:8] wall_texture
   output logic [0:0]  rsp_tuser,   // [0] no_hit

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CB = grc_pkg::CELL_BITS;
   localparam int SB = grc_pkg::SIDE_BITS;
   localparam int STEP_BITS = $clog2(MAX_STEPS + 1);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DU       = 4'd1;
   localparam logic [3:0] ST_DU_WAIT  = 4'd2;
   localparam logic [3:0] ST_DV       = 4'd3;
   localparam logic [3:0] ST_DV_WAIT  = 4'd4;
   localparam logic [3:0] ST_INIT     = 4'd5;
   localparam logic [3:0] ST_WALK     = 4'd6;
   localparam logic [3:0] ST_TEX      = 4'd7;
   localparam logic [3:0] ST_TEX_WAIT = 4'd8;
   localparam logic [3:0] ST_HEIGHT   = 4'd9;
   localparam logic [3:0] ST_H_WAIT   = 4'd10;
   localparam logic [3:0] ST_OUT      = 4'd11;

   // Control registers
   logic [3:0]           state_ff, state_in;
   logic [10:0]          player_x_ff, player_x_in;
   logic [10:0]          player_y_ff, player_y_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic                 valid_p_ff, valid_p_in;
   logic [STEP_BITS-1:0] n_ff, n_in;

   // Datapath registers
   logic          u_neg_ff, u_neg_in, u_pos_ff, u_pos_in;
   logic          v_neg_ff, v_neg_in, v_pos_ff, v_pos_in;
   logic [15:0]   au_ff, au_in, av_ff, av_in;
   logic [29:0]   du_ff, du_in, dv_ff, dv_in;
   logic [30:0]   distx_ff, distx_in, disty_ff, disty_in;
   logic [CB-1:0] idx_ff, idx_in, idx_p_ff, idx_p_in;
   logic          yside_p_ff, yside_p_in;
   logic [30:0]   hitv_p_ff, hitv_p_in;
   logic [7:0]    tex_ff, tex_in;
   logic [7:0]    height_ff, height_in;
   logic          nohit_ff, nohit_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_user_ff, rsp_user_in;

   // Map memory
   logic [6:0]    map_mem [grc_pkg::CELLS];
   logic [6:0]    rdata_ff;
   logic          mem_we;
   logic [CB-1:0] mem_waddr;
   logic [6:0]    mem_wdata;
   logic [CB-1:0] rd_addr;

   // Reciprocal unit
   logic                    rcp_start;
   logic [15:0]             rcp_operand;
   grc_pkg::rcp_status_type rcp_status;
   logic [32:0]             rcp_result;

   // Request fields
   logic [15:0] req_u, req_v;
   logic [15:0] req_u_neg, req_v_neg;
   assign req_u     = req_tdata[28:13];
   assign req_v     = req_tdata[44:29];
   assign req_u_neg = 16'd0 - req_u;
   assign req_v_neg = 16'd0 - req_v;

   // Walk datapath
   logic          yside_c;
   logic [CB-1:0] stride;
   logic [CB-1:0] idx_next;
   logic [31:0]   sum_x, sum_y;
   logic [30:0]   sat_x, sat_y;
   logic [7:0]    mx, my;
   logic [29:0]   distx_init, disty_init;
   logic [CB-1:0] nb_row, nb_col;
   logic [15:0]   hit16;
   logic [16:0]   hq;
   logic          csr_write;

   assign yside_c = distx_ff > disty_ff;
   assign stride  = yside_c ? (v_neg_ff ? grc_pkg::STRIDE_Y_NEG : grc_pkg::STRIDE_Y_POS)
                            : (u_neg_ff ? grc_pkg::STRIDE_X_NEG : grc_pkg::STRIDE_X_POS);
   assign idx_next = idx_ff + stride;

   // Saturating distance advance
   assign sum_x = {1'b0, distx_ff} + {2'b0, du_ff};
   assign sum_y = {1'b0, disty_ff} + {2'b0, dv_ff};
   assign sat_x = (sum_x > {1'b0, grc_pkg::DIST_MAX}) ? grc_pkg::DIST_MAX : sum_x[30:0];
   assign sat_y = (sum_y > {1'b0, grc_pkg::DIST_MAX}) ? grc_pkg::DIST_MAX : sum_y[30:0];

   // Mirror the fraction when stepping in the positive direction
   assign mx = u_pos_ff ? (grc_pkg::FRAC_MIRROR - player_x_ff[7:0]) : player_x_ff[7:0];
   assign my = v_pos_ff ? (grc_pkg::FRAC_MIRROR - player_y_ff[7:0]) : player_y_ff[7:0];
   assign distx_init = {8'd0, du_ff[29:8]} * {22'd0, mx};
   assign disty_init = {8'd0, dv_ff[29:8]} * {22'd0, my};

   // Neighbor texture cells: row number plus one, column number plus one
   assign nb_row = CB'(idx_p_ff[CB-1 -: SB]) + CB'(1);
   assign nb_col = CB'(idx_p_ff[SB-1:0]) + CB'(1);

   assign hit16 = (hitv_p_ff[30:24] != 7'd0) ? grc_pkg::HIT_SAT : hitv_p_ff[23:8];
   assign hq    = rcp_result[32:16];

   assign csr_write = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      state_in      = state_ff;
      player_x_in   = player_x_ff;
      player_y_in   = player_y_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      valid_p_in    = valid_p_ff;
      n_in          = n_ff;
      u_neg_in      = u_neg_ff;
      u_pos_in      = u_pos_ff;
      v_neg_in      = v_neg_ff;
      v_pos_in      = v_pos_ff;
      au_in         = au_ff;
      av_in         = av_ff;
      du_in         = du_ff;
      dv_in         = dv_ff;
      distx_in      = distx_ff;
      disty_in      = disty_ff;
      idx_in        = idx_ff;
      idx_p_in      = idx_p_ff;
      yside_p_in    = yside_p_ff;
      hitv_p_in     = hitv_p_ff;
      tex_in        = tex_ff;
      height_in     = height_ff;
      nohit_in      = nohit_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      mem_we        = 1'b0;
      mem_waddr     = req_tdata[CB-1:0];
      mem_wdata     = req_tdata[12:6];
      rd_addr       = idx_p_ff;
      rcp_start     = 1'b0;
      rcp_operand   = au_ff;

      if (csr_write) begin
         if (csr_paddr[2] == grc_pkg::REG_PLAYER_X) player_x_in = csr_pwdata[10:0];
         else                                       player_y_in = csr_pwdata[10:0];
      end

      // Drop the output word once taken
      if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0] == grc_pkg::REQ_WRITE) begin
                  mem_we = 1'b1;
               end else begin
                  u_neg_in = req_u[15];
                  u_pos_in = !req_u[15] && (req_u != 16'd0);
                  v_neg_in = req_v[15];
                  v_pos_in = !req_v[15] && (req_v != 16'd0);
                  au_in    = req_u[15] ? req_u_neg : req_u;
                  av_in    = req_v[15] ? req_v_neg : req_v;
                  nohit_in = 1'b0;
                  state_in = ST_DU;
               end
            end
         end
         ST_DU: begin
            if (au_ff < grc_pkg::SMALL_MAG) begin
               du_in    = grc_pkg::STEP_MAX;
               state_in = ST_DV;
            end else begin
               rcp_start = 1'b1;
               state_in  = ST_DU_WAIT;
            end
         end
         ST_DU_WAIT: begin
            if (rcp_status.done) begin
               du_in    = rcp_result[29:0];
               state_in = ST_DV;
            end
         end
         ST_DV: begin
            rcp_operand = av_ff;
            if (av_ff < grc_pkg::SMALL_MAG) begin
               dv_in    = grc_pkg::STEP_MAX;
               state_in = ST_INIT;
            end else begin
               rcp_start = 1'b1;
               state_in  = ST_DV_WAIT;
            end
         end
         ST_DV_WAIT: begin
            if (rcp_status.done) begin
               dv_in    = rcp_result[29:0];
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            distx_in   = {1'b0, distx_init};
            disty_in   = {1'b0, disty_init};
            idx_in     = {player_y_ff[8 +: SB], player_x_ff[8 +: SB]};
            n_in       = '0;
            valid_p_in = 1'b0;
            state_in   = ST_WALK;
         end
         ST_WALK: begin
            // Check the cell read last cycle while the next one is fetched, unless the walk ends here
            if (valid_p_ff && (rdata_ff != 7'd0)) begin
               tex_in     = {1'b0, rdata_ff};
               valid_p_in = 1'b0;
               state_in   = ST_TEX;
            end else if (n_ff == STEP_BITS'(MAX_STEPS)) begin
               height_in  = 8'd0;
               tex_in     = 8'd0;
               nohit_in   = 1'b1;
               valid_p_in = 1'b0;
               state_in   = ST_OUT;
            end else begin
               rd_addr    = idx_next;
               idx_in     = idx_next;
               idx_p_in   = idx_next;
               yside_p_in = yside_c;
               hitv_p_in  = yside_c ? disty_ff : distx_ff;
               if (yside_c) disty_in = sat_y;
               else         distx_in = sat_x;
               n_in       = n_ff + STEP_BITS'(1);
               valid_p_in = 1'b1;
            end
         end
         ST_TEX: begin
            if (yside_p_ff && v_neg_ff) begin
               rd_addr  = nb_row;
               state_in = ST_TEX_WAIT;
            end else if (!yside_p_ff && u_neg_ff) begin
               rd_addr  = nb_col;
               state_in = ST_TEX_WAIT;
            end else begin
               tex_in   = {yside_p_ff, tex_ff[6:0]};
               state_in = ST_HEIGHT;
            end
         end
         ST_TEX_WAIT: begin
            tex_in   = {yside_p_ff, rdata_ff};
            state_in = ST_HEIGHT;
         end
         ST_HEIGHT: begin
            rcp_operand = hit16;
            if (hit16 == 16'd0) begin
               height_in = 8'(HALF_HEIGHT);
               state_in  = ST_OUT;
            end else begin
               rcp_start = 1'b1;
               state_in  = ST_H_WAIT;
            end
         end
         ST_H_WAIT: begin
            if (rcp_status.done) begin
               height_in = (hq > 17'(HALF_HEIGHT)) ? 8'(HALF_HEIGHT) : hq[7:0];
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            // Hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {tex_ff, height_ff};
               rsp_user_in   = nohit_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         player_x_ff   <= grc_pkg::PLAYER_X_RESET;
         player_y_ff   <= grc_pkg::PLAYER_Y_RESET;
         rsp_tvalid_ff <= 1'b0;
         valid_p_ff    <= 1'b0;
         n_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         player_x_ff   <= player_x_in;
         player_y_ff   <= player_y_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         valid_p_ff    <= valid_p_in;
         n_ff          <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      u_neg_ff    <= u_neg_in;
      u_pos_ff    <= u_pos_in;
      v_neg_ff    <= v_neg_in;
      v_pos_ff    <= v_pos_in;
      au_ff       <= au_in;
      av_ff       <= av_in;
      du_ff       <= du_in;
      dv_ff       <= dv_in;
      distx_ff    <= distx_in;
      disty_ff    <= disty_in;
      idx_ff      <= idx_in;
      idx_p_ff    <= idx_p_in;
      yside_p_ff  <= yside_p_in;
      hitv_p_ff   <= hitv_p_in;
      tex_ff      <= tex_in;
      height_ff   <= height_in;
      nohit_ff    <= nohit_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Map memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) map_mem[mem_waddr] <= mem_wdata;
      rdata_ff <= map_mem[rd_addr];
   end

   grc_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (rcp_start),
      .operand (rcp_operand),
      .status  (rcp_status),
      .result  (rcp_result)
   );

   assign req_tready   = (state_ff == ST_IDLE);
   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;
   assign csr_pready   = 1'b1;
   assign csr_prdata   = (csr_paddr[2] == grc_pkg::REG_PLAYER_Y) ? {21'd0, player_y_ff}
                                                                : {21'd0, player_x_ff};

`ifndef ASSERT_OFF
   a_idle_rcp_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rcp_status.busy)
      else $error("reciprocal unit busy while idle");

   a_rcp_done_waited: assert property (@(posedge clock) disable iff (reset)
      rcp_status.done |->
         (state_ff == ST_DU_WAIT || state_ff == ST_DV_WAIT || state_ff == ST_H_WAIT))
      else $error("reciprocal result arrived with no consumer");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (n_ff <= STEP_BITS'(MAX_STEPS)))
      else $error("walk exceeded step bound");

   a_nohit_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_user_ff) |-> (rsp_data_ff == 16'd0))
      else $error("no-hit word carries data");

   a_height_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (rsp_data_ff[7:0] <= 8'(HALF_HEIGHT)))
      else $error("wall height above bound");
`endif

endmodule
